/* rtl/lsc_pkg.sv */
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types, codes and widths for the least-squares sensor calibrator.
// ----------------------------------------------------------------------------
`default_nettype none

package lsc_pkg;

  localparam int MAX_POINTS_DEF = 8;

  // register indexes
  localparam logic [0:0] REG_MV_AT_20C = 1'd0;
  localparam logic [0:0] REG_MV_AT_30C = 1'd1;
  localparam logic [11:0] MV_AT_20C_RST = 12'd700;
  localparam logic [11:0] MV_AT_30C_RST = 12'd800;

  // action codes
  localparam logic [1:0] ACT_CONVERT   = 2'd0;
  localparam logic [1:0] ACT_CALIBRATE = 2'd1;
  localparam logic [1:0] ACT_CLEAR     = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ZERO_VOLT  = 2'd1;
  localparam logic [1:0] ST_DEGENERATE = 2'd2;

  // datapath widths, sized for the largest store of 32 points
  localparam int STW   = 14;  // sum of temperatures
  localparam int SVW   = 18;  // sum of voltages
  localparam int STVW  = 27;  // sum of t*v
  localparam int STTW  = 22;  // sum of t*t
  localparam int PW    = 34;  // n*stv - st*sv
  localparam int QW    = 26;  // n*stt - st*st
  localparam int NVW   = 19;  // n*v
  localparam int NUMW  = 48;
  localparam int DENW  = 40;
  localparam int DIVW  = 50;
  localparam int MAW   = 35;  // multiplier operand a
  localparam int MBW   = 27;  // multiplier operand b
  localparam int PRODW = MAW + MBW;

  typedef struct packed {
    logic [1:0]        action;
    logic [11:0]       reading_mv;
    logic signed [7:0] ref_temp;
  } in_t;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic [1:0]         status;
    logic               fit_is_custom;
    logic [3:0]         stored_points;
  } out_t;

  // write request into the point store
  typedef struct packed {
    logic              we;
    logic              shift;
    logic signed [7:0] temp;
    logic [11:0]       volt;
  } store_wr_t;

endpackage

`default_nettype wire

/* rtl/least_squares_sensor_calibrator.sv */
// Operation: convert with a custom fit accumulates each stored point, runs up to 10 fit
//   steps on the shared multiplier, then normalizes and runs the serial divider.
// Convert on the default fit computes its terms, then normalizes and divides; calibrate
//   scans the stored points; clear and zero-voltage requests go straight to the result.
// Throughput: one request at a time; a new request is taken once the previous one is done.
// Reset: synchronous, clears the point count and loads the default millivolt registers.
// ----------------------------------------------------------------------------
// least_squares_sensor_calibrator
// Least-squares temperature fit over stored calibration points, one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module least_squares_sensor_calibrator #(
  parameter int MAX_POINTS = lsc_pkg::MAX_POINTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire lsc_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output lsc_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic [0:0]    cfg_index,
  input  wire logic [11:0]   cfg_data
);

  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int IW    = $clog2(MAX_POINTS);
  localparam int NUMW  = lsc_pkg::NUMW;
  localparam int DENW  = lsc_pkg::DENW;
  localparam int DIVW  = lsc_pkg::DIVW;
  localparam int MAW   = lsc_pkg::MAW;
  localparam int MBW   = lsc_pkg::MBW;
  localparam int PRODW = lsc_pkg::PRODW;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_ACC, S_FIT, S_DEF, S_NORM, S_DIV, S_DONE
  } state_t;

  state_t                          state;
  lsc_pkg::in_t                    req;
  logic [CW-1:0]                   cnt;
  logic [11:0]                     mv20;
  logic [11:0]                     mv30;
  logic [IW-1:0]                   idx;
  logic [1:0]                      phase;
  logic [3:0]                      fstep;
  logic signed [lsc_pkg::STW-1:0]  st;
  logic signed [lsc_pkg::SVW-1:0]  sv;
  logic signed [lsc_pkg::STVW-1:0] stv;
  logic signed [lsc_pkg::STTW-1:0] stt;
  logic signed [lsc_pkg::PW-1:0]   p;
  logic signed [lsc_pkg::QW-1:0]   qq;
  logic signed [lsc_pkg::NVW-1:0]  nv;
  logic signed [NUMW-1:0]          num;
  logic signed [DENW-1:0]          den;
  logic signed [PRODW-1:0]         prod;
  logic                            neg;
  logic signed [15:0]              res_temp;
  logic [1:0]                      res_status;

  logic signed [MAW-1:0]  mul_a;
  logic signed [MBW-1:0]  mul_b;
  logic signed [7:0]      rd_temp;
  logic [11:0]            rd_volt;
  lsc_pkg::store_wr_t     wr;
  logic [IW-1:0]          wr_idx;
  logic                   last_pt;
  logic                   near;
  logic signed [8:0]      tdiff;
  logic signed [12:0]     v_s;
  logic signed [12:0]     t_v;
  logic signed [CW:0]     n_s;
  logic signed [12:0]     dd;
  logic signed [DENW-1:0] den_abs;
  logic signed [NUMW-1:0] num_adj;
  logic signed [NUMW+1:0] n2;
  logic [DIVW-1:0]        div_n;
  logic [DIVW-1:0]        div_d;
  logic                   div_start;
  logic                   div_done;
  logic [DIVW-1:0]        div_q;
  logic [CW+3:0]          cnt_ext;

  assign in_stall = (state != S_IDLE);
  assign last_pt  = ((CW'(idx) + CW'(1)) == cnt);
  assign tdiff    = 9'(rd_temp) - 9'(req.ref_temp);
  assign near     = (tdiff >= -9'sd1) && (tdiff <= 9'sd1);
  assign v_s      = signed'({1'b0, req.reading_mv});
  assign t_v      = signed'({1'b0, rd_volt});
  assign n_s      = signed'({1'b0, cnt});
  assign dd       = signed'({1'b0, mv30}) - signed'({1'b0, mv20});
  assign cnt_ext  = {4'd0, cnt};

  // sign normalization ahead of the divide
  assign den_abs = den[DENW-1] ? -den : den;
  assign num_adj = den[DENW-1] ? -num : num;
  assign n2      = (NUMW+2)'(num_adj) * 2 + (NUMW+2)'(den_abs);
  assign div_n   = n2[NUMW+1] ? DIVW'(-n2) : DIVW'(n2);
  assign div_d   = DIVW'({den_abs, 1'b0});
  assign div_start = (state == S_NORM);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_ACC: begin
        mul_a = (phase == 2'd1) ? MAW'(rd_temp) : MAW'(t_v);
        mul_b = MBW'(rd_temp);
      end
      S_FIT: begin
        unique case (fstep)
          4'd0: begin mul_a = MAW'(stv); mul_b = MBW'(n_s); end
          4'd1: begin mul_a = MAW'(sv);  mul_b = MBW'(st);  end
          4'd2: begin mul_a = MAW'(stt); mul_b = MBW'(n_s); end
          4'd3: begin mul_a = MAW'(st);  mul_b = MBW'(st);  end
          4'd4: begin mul_a = MAW'(v_s); mul_b = MBW'(n_s); end
          4'd5: begin mul_a = MAW'(sv);  mul_b = MBW'(qq);  end
          4'd6: begin mul_a = MAW'(nv);  mul_b = MBW'(qq);  end
          4'd7: begin mul_a = MAW'(p);   mul_b = MBW'(st);  end
          4'd8: begin mul_a = MAW'(p);   mul_b = MBW'(n_s); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // store write request
  always_comb begin
    wr      = '0;
    wr.temp = req.ref_temp;
    wr.volt = req.reading_mv;
    wr_idx  = idx;
    if (state == S_SCAN) begin
      if (cnt == '0) begin
        wr.we  = 1'b1;
        wr_idx = '0;
      end else if (near) begin
        wr.we = 1'b1;
      end else if (last_pt) begin
        wr.we = 1'b1;
        if (cnt == CW'(MAX_POINTS)) begin
          wr.shift = 1'b1;
        end else begin
          wr_idx = IW'(cnt);
        end
      end
    end
  end

  lsc_store #(.MAX_POINTS(MAX_POINTS)) u_store (
    .clk     (clk),
    .wr      (wr),
    .wr_idx  (wr_idx),
    .rd_idx  (idx),
    .rd_temp (rd_temp),
    .rd_volt (rd_volt)
  );

  lsc_div #(.W(DIVW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      mv20       <= lsc_pkg::MV_AT_20C_RST;
      mv30       <= lsc_pkg::MV_AT_30C_RST;
      out_valid  <= 1'b0;
      idx        <= '0;
      phase      <= '0;
      fstep      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lsc_pkg::REG_MV_AT_20C: mv20 <= cfg_data;
          lsc_pkg::REG_MV_AT_30C: mv30 <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req        <= in_data;
            res_temp   <= '0;
            res_status <= lsc_pkg::ST_OK;
            idx        <= '0;
            phase      <= '0;
            fstep      <= '0;
            st         <= '0;
            sv         <= '0;
            stv        <= '0;
            stt        <= '0;
            state      <= S_DONE;
            unique case (in_data.action)
              lsc_pkg::ACT_CONVERT: begin
                if (in_data.reading_mv == '0) begin
                  res_status <= lsc_pkg::ST_ZERO_VOLT;
                end else if (cnt < CW'(2)) begin
                  state <= S_DEF;
                end else begin
                  state <= S_ACC;
                end
              end
              lsc_pkg::ACT_CALIBRATE: begin
                if (in_data.reading_mv == '0) begin
                  res_status <= lsc_pkg::ST_ZERO_VOLT;
                end else begin
                  state <= S_SCAN;
                end
              end
              lsc_pkg::ACT_CLEAR: cnt <= '0;
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          // first point within one degree wins, else append or shift
          if (cnt == '0) begin
            cnt   <= CW'(1);
            state <= S_DONE;
          end else if (near) begin
            state <= S_DONE;
          end else if (last_pt) begin
            if (cnt != CW'(MAX_POINTS)) begin
              cnt <= cnt + CW'(1);
            end
            state <= S_DONE;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_ACC: begin
          unique case (phase)
            2'd0: phase <= 2'd1;
            2'd1: begin
              stv   <= stv + lsc_pkg::STVW'(prod);
              phase <= 2'd2;
            end
            default: begin
              stt   <= stt + lsc_pkg::STTW'(prod);
              st    <= st + lsc_pkg::STW'(rd_temp);
              sv    <= sv + lsc_pkg::SVW'(t_v);
              phase <= 2'd0;
              if (last_pt) begin
                state <= S_FIT;
              end else begin
                idx <= idx + IW'(1);
              end
            end
          endcase
        end
        S_FIT: begin
          fstep <= fstep + 4'd1;
          unique case (fstep)
            4'd0: ;
            4'd1: p  <= lsc_pkg::PW'(prod);
            4'd2: p  <= p - lsc_pkg::PW'(prod);
            4'd3: qq <= lsc_pkg::QW'(prod);
            4'd4: qq <= qq - lsc_pkg::QW'(prod);
            4'd5: begin
              nv <= lsc_pkg::NVW'(prod);
              if (p == '0 || qq == '0) begin
                res_status <= lsc_pkg::ST_DEGENERATE;
                state      <= S_DONE;
              end
            end
            4'd6: num <= -NUMW'(prod);
            4'd7: num <= num + NUMW'(prod);
            4'd8: num <= num + NUMW'(prod);
            default: begin
              den   <= DENW'(prod);
              state <= S_NORM;
            end
          endcase
        end
        S_DEF: begin
          if (dd == '0) begin
            res_status <= lsc_pkg::ST_DEGENERATE;
            state      <= S_DONE;
          end else begin
            num   <= NUMW'(v_s - signed'({1'b0, mv20})) * 10 + NUMW'(dd) * 20;
            den   <= DENW'(dd);
            state <= S_NORM;
          end
        end
        S_NORM: begin
          neg   <= n2[NUMW+1];
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            // truncate toward zero, then saturate to 16 bits
            if (!neg) begin
              res_temp <= (div_q > DIVW'(32767)) ? 16'sd32767 : signed'(div_q[15:0]);
            end else begin
              res_temp <= (div_q > DIVW'(32768)) ? -16'sd32768 : signed'(16'(-div_q[16:0]));
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid              <= 1'b1;
            out_data.temperature   <= res_temp;
            out_data.status        <= res_status;
            out_data.fit_is_custom <= (cnt >= CW'(2));
            out_data.stored_points <= cnt_ext[3:0];
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/lsc_store.sv */
// ----------------------------------------------------------------------------
// lsc_store
// Calibration point store with one read index, indexed write and shift-down.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_store #(
  parameter int MAX_POINTS = lsc_pkg::MAX_POINTS_DEF
) (
  input  wire logic                          clk,
  input  wire lsc_pkg::store_wr_t            wr,
  input  wire logic [$clog2(MAX_POINTS)-1:0] wr_idx,
  input  wire logic [$clog2(MAX_POINTS)-1:0] rd_idx,
  output logic signed [7:0]                  rd_temp,
  output logic [11:0]                        rd_volt
);

  logic signed [7:0] temps [MAX_POINTS];
  logic [11:0]       volts [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      if (wr.shift) begin
        // drop the oldest point, new one goes to the top
        for (int i = 0; i < MAX_POINTS - 1; i++) begin
          temps[i] <= temps[i+1];
          volts[i] <= volts[i+1];
        end
        temps[MAX_POINTS-1] <= wr.temp;
        volts[MAX_POINTS-1] <= wr.volt;
      end else begin
        temps[wr_idx] <= wr.temp;
        volts[wr_idx] <= wr.volt;
      end
    end
  end

  assign rd_temp = temps[rd_idx];
  assign rd_volt = volts[rd_idx];

endmodule

`default_nettype wire

/* rtl/lsc_div.sv */
// ----------------------------------------------------------------------------
// lsc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_div #(
  parameter int W = lsc_pkg::DIVW
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quotient
);

  localparam int CNTW = $clog2(W + 1);

  logic [W:0]      rem;
  logic [W-1:0]    quo;
  logic [W-1:0]    dsr;
  logic [CNTW-1:0] left;
  logic            busy;
  logic [W:0]      rem_sh;
  logic [W:0]      trial;

  assign rem_sh = {rem[W-1:0], quo[W-1]};
  assign trial  = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        left <= CNTW'(W);
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        if (!trial[W]) begin
          rem <= trial;
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[W-2:0], 1'b0};
        end
        left <= left - 1'b1;
        if (left == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

/* rtl/lsc_checker.sv */
// ----------------------------------------------------------------------------
// lsc_checker
// Port-level checks on the calibrator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire lsc_pkg::out_t out_data
);

  // busy right after taking a request
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while idle but block not busy after");

  // a held result does not change
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // errors carry a zero temperature
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != lsc_pkg::ST_OK |-> out_data.temperature == 16'sd0)
    else $error("error result with nonzero temperature");

  // two or more points means the custom fit
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.stored_points >= 4'd2 |-> out_data.fit_is_custom)
    else $error("custom fit flag missing");

  // a new result only follows work on a request
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in flight");

endmodule

bind least_squares_sensor_calibrator lsc_checker u_lsc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
